// ===== rtl/i2cmte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the I2C master transaction engine.
// No dependencies; every other file of the block imports this package.
package i2cmte_pkg;

	// Bus phases; each phase but idle lasts one half SCL period.
	localparam logic [4:0] PH_IDLE      = 5'd0;
	localparam logic [4:0] PH_START     = 5'd1;
	localparam logic [4:0] PH_BIT_LOW   = 5'd2;
	localparam logic [4:0] PH_BIT_HIGH  = 5'd3;
	localparam logic [4:0] PH_ACK_LOW   = 5'd4;
	localparam logic [4:0] PH_ACK_HIGH  = 5'd5;
	localparam logic [4:0] PH_RD_LOW    = 5'd6;
	localparam logic [4:0] PH_RD_HIGH   = 5'd7;
	localparam logic [4:0] PH_NACK_LOW  = 5'd8;
	localparam logic [4:0] PH_NACK_HIGH = 5'd9;
	localparam logic [4:0] PH_STOP_LOW  = 5'd10;
	localparam logic [4:0] PH_STOP_HIGH = 5'd11;
	localparam logic [4:0] PH_STOP_REL  = 5'd12;
	localparam logic [4:0] PH_RS_LOW    = 5'd13;
	localparam logic [4:0] PH_RS_HIGH   = 5'd14;

	// Request types.
	localparam logic [1:0] TYPE_ADC_RD = 2'd0;
	localparam logic [1:0] TYPE_EE_RD  = 2'd1;
	localparam logic [1:0] TYPE_EE_WR  = 2'd2;
	localparam logic [1:0] TYPE_NONE   = 2'd3;

	// Position within the transaction.
	localparam logic [2:0] STEP_DEV  = 3'd0;
	localparam logic [2:0] STEP_ADDR = 3'd1;
	localparam logic [2:0] STEP_DATA = 3'd2;
	localparam logic [2:0] STEP_READ = 3'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] CFG_ADC_ADDR    = 2'd1;
	localparam logic [1:0] CFG_EE_ADDR     = 2'd2;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
	localparam logic [6:0]  ADC_ADDR_RESET    = 7'd72;
	localparam logic [6:0]  EE_ADDR_RESET     = 7'd80;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic       req_valid;
		logic [1:0] req_type;
		logic [7:0] req_addr;
		logic [7:0] req_data;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_pull_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       nack_error;
	} res_t;

	typedef struct packed {
		logic [15:0] half_period_ticks;
		logic [6:0]  adc_device_address;
		logic [6:0]  eeprom_device_address;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/i2cmte_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bus sequencer of the I2C master: transaction state and the per-tick update.
// Depends on i2cmte_pkg.
module i2cmte_core #(
	parameter int DIVIDER_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire i2cmte_pkg::req_t req,
	input  wire i2cmte_pkg::cfg_t cfg,
	output i2cmte_pkg::res_t      res
);
	import i2cmte_pkg::*;

	localparam int CW = (DIVIDER_BITS + 1 > 17) ? DIVIDER_BITS + 1 : 17;

	logic [4:0]              phase_q, phase_n;
	logic [DIVIDER_BITS-1:0] div_q, div_n;
	logic [3:0]              bit_q, bit_n;
	logic [7:0]              shift_q, shift_n;
	logic [2:0]              step_q, step_n;
	logic [1:0]              type_q, type_n;
	logic [7:0]              addr_q, addr_n;
	logic [7:0]              data_q, data_n;
	logic [7:0]              rx_q, rx_n;
	logic                    err_q, err_n;

	logic [15:0]   hp;
	logic [CW-1:0] div_inc_ext;
	logic          phase_end;
	logic [6:0]    dev_addr;
	logic [3:0]    bit_inc;
	logic [7:0]    rd_shift;
	logic          done;
	logic          scl;
	logic          pull;

	assign hp          = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
	assign div_inc_ext = CW'(div_q) + CW'(1);
	// The divider also wraps at its own width, which caps a phase length.
	assign phase_end   = (div_inc_ext >= CW'(hp)) || (&div_q);
	assign dev_addr    = (type_q == TYPE_ADC_RD) ? cfg.adc_device_address
	                                             : cfg.eeprom_device_address;
	assign bit_inc     = bit_q + 4'd1;
	assign rd_shift    = {shift_q[6:0], req.sda_in};

	always_comb begin
		phase_n = phase_q;
		div_n   = div_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		step_n  = step_q;
		type_n  = type_q;
		addr_n  = addr_q;
		data_n  = data_q;
		rx_n    = rx_q;
		err_n   = err_q;
		done    = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (req.req_valid && (req.req_type != TYPE_NONE)) begin
				type_n  = req.req_type;
				addr_n  = req.req_addr;
				data_n  = req.req_data;
				err_n   = 1'b0;
				step_n  = STEP_DEV;
				bit_n   = 4'd0;
				div_n   = '0;
				phase_n = PH_START;
			end
		end else if (phase_end) begin
			div_n = '0;
			case (phase_q)
				PH_START: begin
					shift_n = {dev_addr, (step_q == STEP_DATA)};
					bit_n   = 4'd0;
					phase_n = PH_BIT_LOW;
				end
				PH_BIT_LOW:  phase_n = PH_BIT_HIGH;
				PH_BIT_HIGH: begin
					shift_n = {shift_q[6:0], 1'b0};
					bit_n   = bit_inc;
					phase_n = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
				end
				PH_ACK_LOW:  phase_n = PH_ACK_HIGH;
				PH_ACK_HIGH: begin
					if (req.sda_in) begin
						// No acknowledge: abort straight into the stop sequence.
						err_n   = 1'b1;
						phase_n = PH_STOP_LOW;
					end else if (step_q == STEP_DEV) begin
						step_n  = STEP_ADDR;
						shift_n = addr_q;
						bit_n   = 4'd0;
						phase_n = PH_BIT_LOW;
					end else if (step_q == STEP_ADDR) begin
						step_n = STEP_DATA;
						if (type_q == TYPE_EE_WR) begin
							shift_n = data_q;
							bit_n   = 4'd0;
							phase_n = PH_BIT_LOW;
						end else begin
							phase_n = PH_RS_LOW;
						end
					end else if (type_q == TYPE_EE_WR) begin
						phase_n = PH_STOP_LOW;
					end else begin
						step_n  = STEP_READ;
						bit_n   = 4'd0;
						shift_n = 8'd0;
						phase_n = PH_RD_LOW;
					end
				end
				PH_RD_LOW:  phase_n = PH_RD_HIGH;
				PH_RD_HIGH: begin
					shift_n = rd_shift;
					bit_n   = bit_inc;
					if (bit_inc >= BITS_PER_BYTE) begin
						rx_n    = rd_shift;
						phase_n = PH_NACK_LOW;
					end else begin
						phase_n = PH_RD_LOW;
					end
				end
				PH_NACK_LOW:  phase_n = PH_NACK_HIGH;
				PH_NACK_HIGH: phase_n = PH_STOP_LOW;
				PH_STOP_LOW:  phase_n = PH_STOP_HIGH;
				PH_STOP_HIGH: phase_n = PH_STOP_REL;
				PH_STOP_REL:  phase_n = PH_IDLE;
				PH_RS_LOW:    phase_n = PH_RS_HIGH;
				PH_RS_HIGH:   phase_n = PH_START;
				default:      phase_n = PH_IDLE;
			endcase
			done = (phase_n == PH_IDLE);
		end else begin
			div_n = div_q + DIVIDER_BITS'(1);
		end
	end

	// Line levels follow the phase the tick ends in.
	always_comb begin
		case (phase_n)
			PH_START: begin
				scl = 1'b1; pull = 1'b1;
			end
			PH_BIT_LOW: begin
				scl = 1'b0; pull = ~shift_n[7];
			end
			PH_BIT_HIGH: begin
				scl = 1'b1; pull = ~shift_n[7];
			end
			PH_ACK_LOW, PH_RD_LOW, PH_NACK_LOW, PH_RS_LOW: begin
				scl = 1'b0; pull = 1'b0;
			end
			PH_STOP_LOW: begin
				scl = 1'b0; pull = 1'b1;
			end
			PH_STOP_HIGH: begin
				scl = 1'b1; pull = 1'b1;
			end
			default: begin
				scl = 1'b1; pull = 1'b0;
			end
		endcase
	end

	assign res.scl_level    = scl;
	assign res.sda_pull_low = pull;
	assign res.busy_res     = (phase_n != PH_IDLE);
	assign res.done_res     = done;
	assign res.read_byte    = rx_n;
	assign res.nack_error   = err_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			div_q   <= '0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			step_q  <= STEP_DEV;
			type_q  <= TYPE_ADC_RD;
			addr_q  <= 8'd0;
			data_q  <= 8'd0;
			rx_q    <= 8'd0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			div_q   <= div_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			step_q  <= step_n;
			type_q  <= type_n;
			addr_q  <= addr_n;
			data_q  <= data_n;
			rx_q    <= rx_n;
			err_q   <= err_n;
		end
	end

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |-> (phase_q != PH_IDLE))
		else $error("done raised while the engine was idle");

	a_start_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_q == PH_IDLE) && req.req_valid &&
		(req.req_type == TYPE_ADC_RD || req.req_type == TYPE_EE_RD ||
		 req.req_type == TYPE_EE_WR)
		|=> (phase_q == PH_START) && !err_q)
		else $error("accepted request did not start a clean transaction");

	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BITS_PER_BYTE)
		else $error("bit counter ran past one byte");

endmodule

`default_nettype wire

// ===== rtl/i2cmte_outbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result register with a one-entry skid stage, so a tick is taken while a result waits.
// Depends on i2cmte_pkg.
module i2cmte_outbuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire i2cmte_pkg::res_t push_data,
	output logic                  full,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output i2cmte_pkg::res_t      out_data
);
	import i2cmte_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with an empty result register");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid stage filled while the result register was free");

endmodule

`default_nettype wire

// ===== rtl/i2c_master_transaction_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the I2C master transaction engine: configuration registers,
// sequencer and result buffer. Depends on i2cmte_pkg, i2cmte_core, i2cmte_outbuf.

// Each input beat is one tick of the bus sequencer and yields exactly one result beat
// carrying the SCL level, SDA drive and status for that tick. The state update is a
// single pass of logic from the sequencer registers into the result register, so one
// beat is taken every clock cycle; in_stall rises only once the result register and
// its one-entry skid stage are both occupied by beats that out_stall holds back.
// A bus half period lasts half_period_ticks input beats (0 acts as 1), capped at
// 2^DIVIDER_BITS. Configuration writes are always ready and should be made while the
// engine is idle.
module i2c_master_transaction_engine_top #(
	parameter int DIVIDER_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire i2cmte_pkg::req_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output i2cmte_pkg::res_t       out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);
	import i2cmte_pkg::*;

	cfg_t cfg_q;
	res_t step_res;
	logic buf_full;
	logic in_fire;

	assign cfg_ready = 1'b1;
	assign in_stall  = buf_full;
	assign in_fire   = in_valid && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks     <= HALF_PERIOD_RESET;
			cfg_q.adc_device_address    <= ADC_ADDR_RESET;
			cfg_q.eeprom_device_address <= EE_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HALF_PERIOD: cfg_q.half_period_ticks     <= cfg_data;
				CFG_ADC_ADDR:    cfg_q.adc_device_address    <= cfg_data[6:0];
				CFG_EE_ADDR:     cfg_q.eeprom_device_address <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	i2cmte_core #(
		.DIVIDER_BITS(DIVIDER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_fire),
		.req    (in_data),
		.cfg    (cfg_q),
		.res    (step_res)
	);

	i2cmte_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_data (step_res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
